[design/page_block_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// page block allocator assertion macros
// shared property forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PAGE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pba_pkg.sv]
// ----------------------------------------------------------------------------
// page block allocator package
// field widths and the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int ADDR_W  = 32;
	localparam int ORDER_W = 3;
	localparam int PAGES_W = 6;

	typedef struct packed {
		logic capture;
		logic find;
		logic load;
		logic split;
		logic emit;
	} pba_cmd_t;

	typedef struct packed {
		logic alloc_hit;
		logic j_zero;
		logic j_one;
	} pba_sts_t;

endpackage

[design/pba_req_if.sv]
// ----------------------------------------------------------------------------
// page block allocator request channel
// valid/ready handshake carrying one add or allocate request
// ----------------------------------------------------------------------------
interface pba_req_if;
	import pba_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [ORDER_W-1:0] block_order;
	logic [ADDR_W-1:0]  base_addr;
	logic [PAGES_W-1:0] page_count;

	modport source (output valid, output kind, output block_order, output base_addr,
		output page_count, input ready);
	modport sink (input valid, input kind, input block_order, input base_addr,
		input page_count, output ready);
endinterface

[design/pba_rsp_if.sv]
// ----------------------------------------------------------------------------
// page block allocator response channel
// valid/ready handshake carrying one result per request
// ----------------------------------------------------------------------------
interface pba_rsp_if;
	import pba_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic [ADDR_W-1:0] granted_address;
	logic              lost;

	modport source (output valid, output ok, output granted_address, output lost,
		input ready);
	modport sink (input valid, input ok, input granted_address, input lost,
		output ready);
endinterface

[design/pba_datapath.sv]
// ----------------------------------------------------------------------------
// page block allocator datapath
// free list storage, order search, pop and the split walk that pushes pieces
// ----------------------------------------------------------------------------
`include "page_block_allocator_unit_assert.svh"

module pba_datapath #(
	parameter int NUM_ORDERS = 6,
	parameter int PAGE_BYTES = 4096,
	parameter int LIST_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pba_pkg::pba_cmd_t             cmd,
	output pba_pkg::pba_sts_t             sts,
	input  logic                          kind,
	input  logic [pba_pkg::ORDER_W-1:0]   block_order,
	input  logic [pba_pkg::ADDR_W-1:0]    base_addr,
	input  logic [pba_pkg::PAGES_W-1:0]   page_count,
	output logic                          ok,
	output logic [pba_pkg::ADDR_W-1:0]    granted_address,
	output logic                          lost
);
	import pba_pkg::*;

	localparam int OW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int XW = NUM_ORDERS + PAGES_W;

	logic               kind_q;
	logic [ORDER_W-1:0] order_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [PAGES_W-1:0] num_q;

	logic [ADDR_W-1:0] store_q [NUM_ORDERS][LIST_DEPTH];
	logic [PW-1:0]     head_q  [NUM_ORDERS];
	logic [PW-1:0]     tail_q  [NUM_ORDERS];
	logic [CW-1:0]     count_q [NUM_ORDERS];

	logic [ADDR_W-1:0]     rd_q;
	logic [ADDR_W-1:0]     piece_q;
	logic [ADDR_W-1:0]     bytes_q;
	logic [NUM_ORDERS-1:0] rest_q;
	logic [OW-1:0]         j_q;
	logic                  res_ok_q;
	logic                  res_lost_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic                  ok_q;
	logic                  lost_q;
	logic [ADDR_W-1:0]     granted_q;

	logic [OW-1:0]         tgt;
	logic                  tgt_ok;
	logic [OW-1:0]         sel;
	logic                  hit;
	logic                  alloc_hit;
	logic                  add_ord_ok;
	logic [OW-1:0]         jj;
	logic [OW-1:0]         wr_ord;
	logic                  wr_req;
	logic                  wr_full;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_data;
	logic                  pop;
	logic [NUM_ORDERS-1:0] rest_d;

	// smallest fitting order, then first non-empty list at or above it
	always_comb begin
		tgt    = '0;
		tgt_ok = 1'b0;
		for (int o = NUM_ORDERS - 1; o >= 0; o--) begin
			if ((XW'(1) << o) >= XW'(num_q)) begin
				tgt    = OW'(o);
				tgt_ok = 1'b1;
			end
		end
		sel = '0;
		hit = 1'b0;
		for (int o = NUM_ORDERS - 1; o >= 0; o--) begin
			if (OW'(o) >= tgt && count_q[o] != '0) begin
				sel = OW'(o);
				hit = 1'b1;
			end
		end
	end

	assign alloc_hit  = kind_q && (num_q != '0) && tgt_ok && hit;
	assign add_ord_ok = !kind_q && ({29'b0, order_q} < 32'(NUM_ORDERS));
	assign jj         = j_q - OW'(1);
	assign wr_ord     = cmd.find ? OW'(order_q) : jj;
	assign wr_req     = (cmd.find && add_ord_ok) || (cmd.split && rest_q[jj]);
	assign wr_full    = count_q[wr_ord] == CW'(LIST_DEPTH);
	assign wr_en      = wr_req && !wr_full;
	assign wr_data    = cmd.find ? addr_q : piece_q;
	assign pop        = cmd.find && alloc_hit;
	assign rest_d     = NUM_ORDERS'((XW'(1) << sel) - XW'(num_q));

	assign sts.alloc_hit = alloc_hit;
	assign sts.j_zero    = j_q == '0;
	assign sts.j_one     = j_q == OW'(1);

	// list pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int o = 0; o < NUM_ORDERS; o++) begin
				head_q[o]  <= '0;
				tail_q[o]  <= '0;
				count_q[o] <= '0;
			end
		end else begin
			for (int o = 0; o < NUM_ORDERS; o++) begin
				if (wr_en && wr_ord == OW'(o)) begin
					tail_q[o]  <= (tail_q[o] == PW'(LIST_DEPTH - 1)) ? '0 : tail_q[o] + 1'b1;
					count_q[o] <= count_q[o] + 1'b1;
				end
				if (pop && sel == OW'(o)) begin
					head_q[o]  <= (head_q[o] == PW'(LIST_DEPTH - 1)) ? '0 : head_q[o] + 1'b1;
					count_q[o] <= count_q[o] - 1'b1;
				end
			end
		end
	end

	// free list storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ord][tail_q[wr_ord]] <= wr_data;
		end
		if (pop) begin
			rd_q <= store_q[sel][head_q[sel]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			order_q <= block_order;
			addr_q  <= base_addr;
			num_q   <= page_count;
		end
		if (cmd.find) begin
			res_ok_q   <= kind_q ? alloc_hit : (add_ord_ok && !wr_full);
			res_lost_q <= add_ord_ok && wr_full;
			res_addr_q <= '0;
			rest_q     <= rest_d;
			j_q        <= sel;
			bytes_q    <= 32'(num_q) * 32'(PAGE_BYTES);
		end
		if (cmd.load) begin
			res_addr_q <= rd_q;
			piece_q    <= rd_q + bytes_q;
		end
		if (cmd.split) begin
			if (wr_req && wr_full) begin
				res_lost_q <= 1'b1;
			end
			if (rest_q[jj]) begin
				piece_q <= piece_q + (32'(PAGE_BYTES) << jj);
			end
			j_q <= jj;
		end
		if (cmd.emit) begin
			ok_q      <= res_ok_q;
			lost_q    <= res_lost_q;
			granted_q <= res_addr_q;
		end
	end

	assign ok              = ok_q;
	assign lost            = lost_q;
	assign granted_address = granted_q;

	`PBA_ASSERT_NOW(a_pop_nonempty, pop, count_q[sel] != '0, "pop from an empty free list")
	`PBA_ASSERT_NOW(a_rest_fits, cmd.load, (XW'(rest_q) >> j_q) == '0, "split tail exceeds block")
	`PBA_ASSERT_NEXT(a_walk_down, cmd.split, j_q == $past(j_q) - OW'(1), "split walk skipped an order")

endmodule

[design/pba_controller.sv]
// ----------------------------------------------------------------------------
// page block allocator controller
// sequences capture, search, pop, split walk and the result hand-off
// ----------------------------------------------------------------------------
`include "page_block_allocator_unit_assert.svh"

module pba_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pba_pkg::pba_cmd_t cmd,
	input  pba_pkg::pba_sts_t sts
);
	import pba_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		FIND,
		LOAD,
		SPLIT,
		DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && (state_q == IDLE);
		cmd.find    = state_q == FIND;
		cmd.load    = state_q == LOAD;
		cmd.split   = state_q == SPLIT;
		cmd.emit    = (state_q == DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= FIND;
					end
				end
				FIND: begin
					state_q <= sts.alloc_hit ? LOAD : DONE;
				end
				LOAD: begin
					state_q <= sts.j_zero ? DONE : SPLIT;
				end
				SPLIT: begin
					if (sts.j_one) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`PBA_ASSERT_NEXT(a_accept_find, in_valid && in_ready, state_q == FIND, "accepted request not searched")
	`PBA_ASSERT_NEXT(a_split_end, (state_q == SPLIT) && sts.j_one, state_q == DONE, "split walk overran")
	`PBA_ASSERT_NEXT(a_emit_shown, cmd.emit, out_valid_q && (state_q == IDLE), "result not presented")

endmodule

[design/page_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// page block allocator unit
// power-of-two page allocator with one free list per order, split only
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An add request, a rejected request or a
// failed allocate passes through the FIND and DONE states between acceptances;
// a granted allocate also passes through LOAD and then SPLIT for each order below
// the order of the popped block, since the split walk visits each lower order in turn and
// pushes at most one piece per cycle through the single free list write port.
// A finished result waits in the output register while the next request is
// taken. The free lists need no clearing after reset.
module page_block_allocator_unit #(
	parameter int NUM_ORDERS = 6,
	parameter int PAGE_BYTES = 4096,
	parameter int LIST_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	pba_req_if.sink  req,
	pba_rsp_if.source rsp
);
	import pba_pkg::*;

	pba_cmd_t cmd;
	pba_sts_t sts;

	pba_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pba_datapath #(
		.NUM_ORDERS (NUM_ORDERS),
		.PAGE_BYTES (PAGE_BYTES),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (req.kind),
		.block_order     (req.block_order),
		.base_addr       (req.base_addr),
		.page_count      (req.page_count),
		.ok              (rsp.ok),
		.granted_address (rsp.granted_address),
		.lost            (rsp.lost)
	);

endmodule

[tb/sv/pba_tb_pkg.sv]
// ----------------------------------------------------------------------------
// page block allocator testbench package
// request kind codes shared by the stimulus and the monitor
// ----------------------------------------------------------------------------
package pba_tb_pkg;

	typedef enum logic {
		REQ_ADD   = 1'b0,
		REQ_ALLOC = 1'b1
	} req_kind_t;

endpackage

[tb/sv/pba_alloc_monitor.sv]
// ----------------------------------------------------------------------------
// page block allocator monitor
// watches both channels, keeps its own copy of the per-order free lists,
// predicts the outcome of every accepted request and checks each response
// ----------------------------------------------------------------------------
module pba_alloc_monitor #(
	parameter int NUM_ORDERS = 6,
	parameter int PAGE_BYTES = 4096,
	parameter int LIST_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	pba_req_if   req,
	pba_rsp_if   rsp,
	output int   mismatch_count,
	output int   outstanding,
	output int   grants_seen,
	output int   lost_seen
);
	import pba_pkg::*;
	import pba_tb_pkg::*;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] addr;
		logic              lost;
	} alloc_outcome_t;

	logic [ADDR_W-1:0] free_ring [NUM_ORDERS][LIST_DEPTH];
	int                ring_head [NUM_ORDERS];
	int                ring_tail [NUM_ORDERS];
	int                ring_fill [NUM_ORDERS];
	alloc_outcome_t    awaited_outcomes [$];
	int                errors;
	int                grants;
	int                drops;

	function automatic bit free_list_push(int o, logic [ADDR_W-1:0] a);
		if (ring_fill[o] >= LIST_DEPTH)
			return 1'b0;
		free_ring[o][ring_tail[o]] = a;
		ring_tail[o] = (ring_tail[o] + 1) % LIST_DEPTH;
		ring_fill[o]++;
		return 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] free_list_pop(int o);
		logic [ADDR_W-1:0] a;
		a = free_ring[o][ring_head[o]];
		ring_head[o] = (ring_head[o] + 1) % LIST_DEPTH;
		ring_fill[o]--;
		return a;
	endfunction

	function automatic alloc_outcome_t alloc_outcome(logic kind, logic [ORDER_W-1:0] ord,
			logic [ADDR_W-1:0] start, logic [PAGES_W-1:0] pages);
		alloc_outcome_t    r;
		int                need;
		int                src;
		int                rest;
		logic [ADDR_W-1:0] piece;
		r = '0;
		if (kind == REQ_ADD) begin
			if (int'(ord) < NUM_ORDERS) begin
				if (free_list_push(int'(ord), start))
					r.ok = 1'b1;
				else
					r.lost = 1'b1;
			end
		end else if (pages != '0) begin
			need = 0;
			while (need < NUM_ORDERS && (1 << need) < int'(pages))
				need++;
			src = -1;
			for (int o = need; o < NUM_ORDERS; o++)
				if (src < 0 && ring_fill[o] != 0)
					src = o;
			if (src >= 0) begin
				r.ok = 1'b1;
				r.addr = free_list_pop(src);
				rest = (1 << src) - int'(pages);
				piece = r.addr + ADDR_W'(int'(pages) * PAGE_BYTES);
				for (int j = src - 1; j >= 0; j--) begin
					if (rest >= (1 << j)) begin
						rest -= (1 << j);
						if (!free_list_push(j, piece))
							r.lost = 1'b1;
						piece = piece + ADDR_W'((1 << j) * PAGE_BYTES);
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_outcome_t want;
		if (!arst_n) begin
			for (int o = 0; o < NUM_ORDERS; o++) begin
				ring_head[o] = 0;
				ring_tail[o] = 0;
				ring_fill[o] = 0;
				for (int k = 0; k < LIST_DEPTH; k++)
					free_ring[o][k] = '0;
			end
			awaited_outcomes.delete();
			errors = 0;
			grants = 0;
			drops = 0;
			mismatch_count <= 0;
			outstanding <= 0;
			grants_seen <= 0;
			lost_seen <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					want = awaited_outcomes[0];
					awaited_outcomes.delete(0);
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, rsp.ok);
						errors++;
					end
					if (rsp.granted_address !== want.addr) begin
						$error("granted_address: expected %h, got %h", want.addr,
							rsp.granted_address);
						errors++;
					end
					if (rsp.lost !== want.lost) begin
						$error("lost: expected %0d, got %0d", want.lost, rsp.lost);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) begin
				want = alloc_outcome(req.kind, req.block_order, req.base_addr,
					req.page_count);
				if (req.kind == REQ_ALLOC && want.ok)
					grants++;
				if (want.lost)
					drops++;
				awaited_outcomes = {awaited_outcomes, want};
			end
			mismatch_count <= errors;
			outstanding <= awaited_outcomes.size();
			grants_seen <= grants;
			lost_seen <= drops;
		end
	end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// page block allocator unit testbench
// drives add and allocate requests with random gaps and response stalls,
// a directed opening then phases that fill and drain the free lists;
// the monitor beside the block predicts and checks every response
// ----------------------------------------------------------------------------
module tb;
	import pba_pkg::*;
	import pba_tb_pkg::*;

	localparam int RANDOM_ITEMS = 730;
	localparam int CALM_ITEMS   = 100;
	localparam int QUIET_LIMIT  = 2000;

	logic clk = 1'b0;
	logic arst_n;

	pba_req_if req_ch ();
	pba_rsp_if rsp_ch ();

	int  mismatch_count;
	int  outstanding;
	int  grants_seen;
	int  lost_seen;
	int  adds_sent;
	int  allocs_sent;
	int  quiet_cycles;
	bit  gaps_on;
	bit  stalls_on;

	page_block_allocator_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	pba_alloc_monitor alloc_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding),
		.grants_seen   (grants_seen),
		.lost_seen     (lost_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_request(req_kind_t kind, logic [ORDER_W-1:0] ord,
			logic [ADDR_W-1:0] start, logic [PAGES_W-1:0] pages);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.block_order <= ord;
		req_ch.base_addr <= start;
		req_ch.page_count <= pages;
		do @(posedge clk); while (!req_ch.ready);
		if (kind == REQ_ADD)
			adds_sent++;
		else
			allocs_sent++;
	endtask

	task automatic add_block(logic [ORDER_W-1:0] ord, logic [ADDR_W-1:0] start);
		send_request(REQ_ADD, ord, start, PAGES_W'($urandom));
	endtask

	task automatic alloc_pages(logic [PAGES_W-1:0] pages);
		send_request(REQ_ALLOC, ORDER_W'($urandom), ADDR_W'($urandom), pages);
	endtask

	// response side stalls
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 17);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no request or response moved in %0d cycles", QUIET_LIMIT);
			$display("FAIL page_block_allocator_unit");
			$finish;
		end
	end

	initial begin
		bit                 fill_mode;
		int                 focus;
		int                 pick;
		logic [ORDER_W-1:0] ord;
		logic [ADDR_W-1:0]  start;
		logic [PAGES_W-1:0] pages;
		adds_sent = 0;
		allocs_sent = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		fill_mode = 1'b1;
		focus = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= REQ_ADD;
		req_ch.block_order <= '0;
		req_ch.base_addr <= '0;
		req_ch.page_count <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening
		alloc_pages(6'd1);
		alloc_pages(6'd0);
		alloc_pages(6'd63);
		alloc_pages(6'd33);
		add_block(3'd7, 32'h0001_0000);
		add_block(3'd6, 32'h0002_0000);
		add_block(3'd5, 32'hFFFF_F000);
		alloc_pages(6'd1);
		alloc_pages(6'd32);
		add_block(3'd5, 32'h0004_0000);
		alloc_pages(6'd32);
		alloc_pages(6'd16);
		alloc_pages(6'd3);
		alloc_pages(6'd5);
		add_block(3'd0, 32'h0000_0000);
		add_block(3'd1, 32'hFFFF_FFFF);
		alloc_pages(6'd2);
		alloc_pages(6'd1);
		alloc_pages(6'd17);
		send_request(REQ_ALLOC, 3'd7, 32'hFFFF_FFFF, 6'd1);
		send_request(REQ_ADD, 3'd2, 32'h0008_0000, 6'd63);
		alloc_pages(6'd4);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				fill_mode = 1'($urandom_range(0, 1));
				focus = $urandom_range(0, 5);
			end
			if (n == RANDOM_ITEMS - CALM_ITEMS) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			if (fill_mode ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0)) begin
				pick = $urandom_range(0, 11);
				if (pick == 0)
					ord = ORDER_W'($urandom_range(6, 7));
				else if (pick <= 5)
					ord = ORDER_W'(focus);
				else
					ord = ORDER_W'($urandom_range(0, 5));
				start = $urandom;
				if ($urandom_range(0, 9) == 0)
					start = 32'hFFFE_0000 + ($urandom_range(0, 31) << 12);
				else if ($urandom_range(0, 1) == 0)
					start[11:0] = '0;
				add_block(ord, start);
			end else begin
				pick = $urandom_range(0, 15);
				if (pick == 0)
					pages = '0;
				else if (pick == 1)
					pages = PAGES_W'($urandom_range(33, 63));
				else if (pick <= 5)
					pages = PAGES_W'(1 << $urandom_range(0, 5));
				else
					pages = PAGES_W'($urandom_range(1, 32));
				alloc_pages(pages);
			end
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d add and %0d allocate requests", adds_sent, allocs_sent);
		$display("%0d allocations granted, %0d requests dropped a block or piece",
			grants_seen, lost_seen);
		if (mismatch_count == 0)
			$display("PASS page_block_allocator_unit");
		else
			$display("FAIL page_block_allocator_unit");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/pba_pkg.sv
design/pba_req_if.sv
design/pba_rsp_if.sv
design/pba_datapath.sv
design/pba_controller.sv
design/page_block_allocator_unit.sv
tb/sv/pba_tb_pkg.sv
tb/sv/pba_alloc_monitor.sv
tb/sv/tb.sv
